/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on aclk, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/core/esc_pkg.sv */
// ---------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and month tables for the epoch-to-calendar block.
// ---------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

    localparam int DVD_W  = 32;   // divider dividend / quotient width
    localparam int DVS_W  = 17;   // divider divisor / remainder width
    localparam int STEP_W = 6;    // holds up to DVD_W steps

    localparam logic [DVS_W-1:0]  SECS_PER_DAY  = 17'd86400;
    localparam logic [DVS_W-1:0]  SECS_PER_HOUR = 17'd3600;
    localparam logic [DVS_W-1:0]  SECS_PER_MIN  = 17'd60;
    localparam logic [DVS_W-1:0]  DAYS_PER_YEAR = 17'd365;
    localparam logic [7:0]        BASE_YY       = 8'd70;   // 1970 mod 100

    localparam logic [STEP_W-1:0] STEPS_DAY  = 6'd32;  // full input word
    localparam logic [STEP_W-1:0] STEPS_YEAR = 6'd16;  // day count < 2^16
    localparam logic [STEP_W-1:0] STEPS_HOUR = 6'd17;  // second of day < 2^17
    localparam logic [STEP_W-1:0] STEPS_MIN  = 6'd12;  // second of hour < 2^12

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DAYS,
        ST_YEAR,
        ST_ADJ,
        ST_MONTH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                start;
        logic [STEP_W-1:0]   steps;
        logic [DVS_W-1:0]    divisor;
        logic [DVD_W-1:0]    dividend;   // left aligned
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;       // one-cycle pulse
        logic [DVD_W-1:0]    quotient;
        logic [DVS_W-1:0]    remainder;
    } div_stat_t;

    // Day of year on which month idx (0 = January) starts.
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        if (leap && idx >= 4'd2 && idx <= 4'd11) begin
            d = d + 9'd1;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/esc_div.sv */
// ---------------------------------------------------------------------------
// esc_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module esc_div
    import esc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire div_req_t  req,
    output      div_stat_t stat
);

    logic [DVD_W-1:0]  dvd_reg,  dvd_next;
    logic [DVD_W-1:0]  quo_reg,  quo_next;
    logic [DVS_W-1:0]  rem_reg,  rem_next;
    logic [DVS_W-1:0]  dvs_reg,  dvs_next;
    logic [STEP_W-1:0] cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              fits;

    always_comb begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});

        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start) begin
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            quo_next  = '0;
            rem_next  = '0;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            quo_next = {quo_reg[DVD_W-2:0], fits};
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy      = busy_reg;
    assign stat.done      = done_reg;
    assign stat.quotient  = quo_reg;
    assign stat.remainder = rem_reg;

endmodule

`default_nettype wire

/* rtl/core/epoch_seconds_to_calendar.sv */
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts a 32-bit seconds-since-1970 count into time of day and date.
// ---------------------------------------------------------------------------
// One transaction in gives one transaction out. After the input is accepted,
// one divider splits it into days and second of day. The next passes then
// start together: the days are split into years on that divider, and the
// second of day into hours on the other, whose minutes pass follows on the
// second of hour to give minutes and seconds. A flag then marks the time
// split finished, and the output register is loaded. The year split, the
// leap-day correction and the month lookup run alongside the time split and
// add no time. The conversion time is set by two bit-serial restoring
// dividers that retire one quotient bit per cycle. One conversion is in
// flight at a time; s_tready returns as the result is loaded into the output
// register. A finished result sits in the output register, so a new input
// can be taken while the previous result still waits for m_tready; the new
// conversion then holds in its last step until the output register frees.
// Every year divisible by 4 is leap, so the calendar is correct from 1970
// through 2099; 2100 is taken as leap. Year is reported modulo 100.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module epoch_seconds_to_calendar
    import esc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [31:0] s_tdata,    // [31:0] epoch_seconds

    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [39:0] m_tdata     // [5:0] second_of_minute, [11:6] minute_of_hour,
                                         // [16:12] hour_of_day, [21:17] day_of_month,
                                         // [25:22] month_number, [32:26] year_two_digit,
                                         // [39:33] zero
);

    state_t      state_reg, state_next;

    div_req_t    date_req, time_req;
    div_stat_t   date_st,  time_st;

    // time unit: hours pass first, then minutes
    logic        tphase_reg, tphase_next;
    logic        tfin_reg,   tfin_next;
    logic [4:0]  hour_reg,   hour_next;

    logic [7:0]  yoff_reg,   yoff_next;
    logic [8:0]  doy_reg,    doy_next;
    logic [4:0]  day_reg,    day_next;
    logic [3:0]  mon_reg,    mon_next;
    logic [6:0]  yy_reg,     yy_next;

    logic        mvalid_reg, mvalid_next;
    logic [39:0] mdata_reg,  mdata_next;

    logic        s_acc;

    // leap-day correction terms
    logic [7:0]  yq;
    logic [8:0]  yrem;
    logic [7:0]  lp_a, lp_b, yq_dec;

    // month lookup terms
    logic        leap;
    logic [3:0]  midx;
    logic [8:0]  mstart;
    logic [7:0]  yy_sum;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        yq     = date_st.quotient[7:0];
        yrem   = date_st.remainder[8:0];
        yq_dec = yq - 8'd1;
        lp_a   = 8'(({1'b0, yq} + 9'd1) >> 2);
        lp_b   = 8'(({1'b0, yq_dec} + 9'd1) >> 2);

        // a year is leap when 1970 + yoff is divisible by 4
        leap   = (yoff_reg[1:0] == 2'd2);
        midx   = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (doy_reg >= month_start(leap, 4'(i))) begin
                midx = 4'(i);
            end
        end
        mstart = month_start(leap, midx);
        yy_sum = BASE_YY + yoff_reg;
    end

    always_comb begin
        state_next  = state_reg;
        tphase_next = tphase_reg;
        tfin_next   = tfin_reg;
        hour_next   = hour_reg;
        yoff_next   = yoff_reg;
        doy_next    = doy_reg;
        day_next    = day_reg;
        mon_next    = mon_reg;
        yy_next     = yy_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;

        date_req = '{start: 1'b0, steps: STEPS_DAY, divisor: SECS_PER_DAY,
                     dividend: s_tdata};
        time_req = '{start: 1'b0, steps: STEPS_HOUR, divisor: SECS_PER_HOUR,
                     dividend: {date_st.remainder, 15'b0}};

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        // hours pass done: chain the minutes pass on the second of hour
        if (time_st.done) begin
            if (!tphase_reg) begin
                hour_next         = time_st.quotient[4:0];
                tphase_next       = 1'b1;
                time_req.start    = 1'b1;
                time_req.steps    = STEPS_MIN;
                time_req.divisor  = SECS_PER_MIN;
                time_req.dividend = {time_st.remainder[11:0], 20'b0};
            end else begin
                tfin_next = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    date_req.start = 1'b1;
                    tphase_next    = 1'b0;
                    tfin_next      = 1'b0;
                    state_next     = ST_DAYS;
                end
            end
            ST_DAYS: begin
                if (date_st.done) begin
                    // days < 2^16: left align for the year split
                    date_req.start    = 1'b1;
                    date_req.steps    = STEPS_YEAR;
                    date_req.divisor  = DAYS_PER_YEAR;
                    date_req.dividend = {date_st.quotient[15:0], 16'b0};
                    time_req.start    = 1'b1;
                    state_next        = ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (date_st.done) begin
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ: begin
                // leap days before year offset y are (y+1)/4
                if (yrem < {1'b0, lp_a}) begin
                    yoff_next = yq_dec;
                    doy_next  = 9'(yrem + 9'd365 - {1'b0, lp_b});
                end else begin
                    yoff_next = yq;
                    doy_next  = yrem - {1'b0, lp_a};
                end
                state_next = ST_MONTH;
            end
            ST_MONTH: begin
                day_next = 5'(doy_reg - mstart + 9'd1);
                mon_next = midx + 4'd1;
                if (yy_sum >= 8'd200) begin
                    yy_next = 7'(yy_sum - 8'd200);
                end else if (yy_sum >= 8'd100) begin
                    yy_next = 7'(yy_sum - 8'd100);
                end else begin
                    yy_next = yy_sum[6:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (tfin_reg && (!mvalid_reg || m_tready)) begin
                    mvalid_next = 1'b1;
                    mdata_next  = {7'b0, yy_reg, mon_reg, day_reg, hour_reg,
                                   time_st.quotient[5:0], time_st.remainder[5:0]};
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            tphase_reg <= 1'b0;
            tfin_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            tphase_reg <= tphase_next;
            tfin_reg   <= tfin_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hour_reg  <= hour_next;
        yoff_reg  <= yoff_next;
        doy_reg   <= doy_next;
        day_reg   <= day_next;
        mon_reg   <= mon_next;
        yy_reg    <= yy_next;
        mdata_reg <= mdata_next;
    end

    // days / year split
    esc_div u_div_date (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (date_req),
        .stat    (date_st)
    );

    // hour / minute / second split
    esc_div u_div_time (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (time_req),
        .stat    (time_st)
    );

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    // Both dividers are quiet whenever no conversion is in flight.
    `ASSERT_IMPL(a_idle_quiet, state_reg == ST_IDLE, !date_st.busy && !time_st.busy, "divider busy while idle")
    // After acceptance no further input is taken until the result is loaded.
    `ASSERT_NEXT(a_one_in_flight, s_acc, !s_tready, "second input taken during conversion")
    // Day of year from the leap correction stays within a year.
    `ASSERT_IMPL(a_doy_range, state_reg == ST_MONTH, doy_reg < 9'd366, "day of year out of range")
    // Offered results carry a valid month and day.
    `ASSERT_IMPL(a_date_range, m_tvalid, (m_tdata[25:22] >= 4'd1) && (m_tdata[25:22] <= 4'd12) && (m_tdata[21:17] != 5'd0), "month or day out of range")

endmodule

`default_nettype wire

/* sim/epoch_seconds_to_calendar_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar_tb
// Streams epoch second counts into the converter and checks each calendar
// result field by field against an in-bench date/time computation.
// ---------------------------------------------------------------------------

module epoch_seconds_to_calendar_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 600;
    localparam int IDLE_PCT    = 14;
    localparam int HOLD_CYCLES = 400;     // long m_tready hold-off
    localparam int TAIL_CYCLES = 200;

    // Result fields, lowest bits last so the layout matches m_tdata.
    typedef struct packed {
        logic [6:0] pad;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } calendar_t;

    // One pending input; hold_for_drain makes the sender wait until all
    // outstanding results are back before offering it.
    typedef struct {
        logic [31:0] secs;
        bit          hold_for_drain;
    } epoch_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    epoch_item_t epoch_q[$];      // inputs not yet accepted
    calendar_t   calendar_q[$];   // results owed by the block
    logic [31:0] epoch_seen_q[$]; // input behind each owed result, for messages

    int unsigned month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    bit          offer_open;      // a transaction is on s_* and not yet taken
    int          mismatches;
    int          results_seen;
    int          cycle_count;
    int          hold_left;
    bit          hold_done;

    epoch_seconds_to_calendar dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // -----------------------------------------------------------------------
    // Date/time computation. Every year divisible by 4 is leap (2100 too),
    // leap days before year offset y are (y+1)/4.
    // -----------------------------------------------------------------------
    function automatic calendar_t to_calendar(input logic [31:0] secs);
        int unsigned t, days, sod, yoff, rem, doy, year, m, mlen;
        bit          leap;
        calendar_t   c;
        t    = secs;
        days = t / 86400;
        sod  = t % 86400;
        yoff = days / 365;
        rem  = days - 365 * yoff;
        // day count landed in the leap days owed by earlier years
        if (rem < (yoff + 1) / 4) begin
            yoff = yoff - 1;
        end
        doy  = days - 365 * yoff - (yoff + 1) / 4;
        year = 1970 + yoff;
        leap = (year % 4) == 0;
        m    = 0;
        mlen = month_days[0];
        while (m < 11 && doy >= mlen) begin
            doy  = doy - mlen;
            m    = m + 1;
            mlen = month_days[m] + ((leap && m == 1) ? 1 : 0);
        end
        c.pad    = '0;
        c.second = 6'(sod % 60);
        c.minute = 6'((sod % 3600) / 60);
        c.hour   = 5'(sod / 3600);
        c.day    = 5'(doy + 1);
        c.month  = 4'(m + 1);
        c.year   = 7'(year % 100);
        return c;
    endfunction

    function automatic bit roll_idle();
        // quiet stretch: no idling on either side for a while mid-run
        if (results_seen >= 250 && results_seen < 400) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got, input logic [31:0] secs);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] mismatch %s for epoch 0x%08h: expected %0d, got %0d",
                         $time, fname, secs, want, got);
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Sender: offers the head of epoch_q at the falling edge, holds it until
    // the monitor sees the transaction taken.
    // -----------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!offer_open) begin
            if (epoch_q.size() > 0 &&
                !(epoch_q[0].hold_for_drain && calendar_q.size() > 0) &&
                !roll_idle()) begin
                s_tvalid   <= 1'b1;
                s_tdata    <= epoch_q[0].secs;
                offer_open = 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off after the first
    // results so the block backs up and drops s_tready while the sender
    // keeps offering.
    // -----------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left = hold_left - 1;
        end else if (!hold_done && results_seen >= 60) begin
            m_tready  <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end else begin
            m_tready <= !roll_idle();
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: input transactions queue their expected calendar result,
    // output transactions are compared with the oldest one.
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        calendar_t   got;
        calendar_t   want;
        logic [31:0] secs;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                calendar_q.push_back(to_calendar(s_tdata));
                epoch_seen_q.push_back(s_tdata);
                void'(epoch_q.pop_front());
                offer_open = 1'b0;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                results_seen++;
                if (calendar_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("[%0t] unexpected result 0x%010h", $time, m_tdata);
                    end
                end else begin
                    want = calendar_q.pop_front();
                    secs = epoch_seen_q.pop_front();
                    check_field("second_of_minute", want.second, got.second, secs);
                    check_field("minute_of_hour",   want.minute, got.minute, secs);
                    check_field("hour_of_day",      want.hour,   got.hour,   secs);
                    check_field("day_of_month",     want.day,    got.day,    secs);
                    check_field("month_number",     want.month,  got.month,  secs);
                    check_field("year_two_digit",   want.year,   got.year,   secs);
                    check_field("reserved bits",    want.pad,    got.pad,    secs);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus and end of run.
    // -----------------------------------------------------------------------
    initial begin
        logic [31:0] directed [$];
        epoch_item_t it;
        int unsigned y;
        int unsigned dstart;
        int unsigned doff;
        int          k;

        directed = {
            32'd0,                // 1970-01-01 00:00:00
            32'hFFFF_FFFF,        // top of range, year 2106
            32'h8000_0000,        // MSB alone
            32'h7FFF_FFFF,
            32'd59, 32'd60,       // minute rollover
            32'd3599, 32'd3600,   // hour rollover
            32'd86399, 32'd86400, // day rollover
            32'd63071999,         // 1971-12-31 23:59:59
            32'd68169600,         // 1972-02-29, first leap day
            32'd68256000,         // 1972-03-01
            32'd94694399,         // 1972-12-31 23:59:59, day 366 of leap year
            32'd94694400,         // 1973-01-01
            32'd189302399,        // 1975-12-31, year offset pulled back
            32'd189302400,        // 1976-01-01
            32'd951782400,        // 2000-02-29
            32'd978307199,        // 2000-12-31 23:59:59
            32'd4102444799,       // 2099-12-31 23:59:59
            32'd4107456000,       // 2100-02-28
            32'd4107542400,       // 2100 taken as leap: Feb 29
            32'd4133980799        // 2100-12-30 in the block's calendar
        };
        foreach (directed[i]) begin
            it.secs           = directed[i];
            it.hold_for_drain = 1'b0;
            epoch_q.push_back(it);
        end

        for (k = 0; k < N_RANDOM; k++) begin
            case ($urandom_range(0, 3))
                0, 1: it.secs = $urandom();
                2: begin
                    // near midnight of a random day
                    it.secs = $urandom_range(0, 49709) * 86400 + $urandom_range(0, 6) - 3;
                end
                default: begin
                    // near a year start, end of February or end of year
                    y      = $urandom_range(0, 136);
                    dstart = 365 * y + (y + 1) / 4;
                    case ($urandom_range(0, 5))
                        0: doff = 0;
                        1: doff = 58;
                        2: doff = 59;
                        3: doff = 60;
                        4: doff = 364;
                        default: doff = 365;
                    endcase
                    it.secs = (dstart + doff) * 86400 + $urandom_range(0, 6) - 3;
                end
            endcase
            // sender waits for a full drain at the start of the random
            // phase and once more midway
            it.hold_for_drain = (k == 0) || (k == N_RANDOM / 2);
            epoch_q.push_back(it);
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (!(epoch_q.size() == 0 && !offer_open && calendar_q.size() == 0)) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
